### sv/rpci_pkg.sv
// ============================================================================
// rpci_pkg
// Shared types, constants, rounding and saturation helpers for the rigid pose
// compose / invert pipeline.
// ============================================================================
`default_nettype none

package rpci_pkg;

    // quaternion fractional bits
    localparam int QFRAC = 14;

    // command codes
    localparam logic CMD_COMPOSE = 1'b0;
    localparam logic CMD_INVERT  = 1'b1;

    // field types
    typedef logic signed [31:0] trans_t;
    typedef logic signed [15:0] qcomp_t;
    typedef logic        [63:0] quat_t;

    // exact sums at 2*QFRAC fractional bits
    typedef logic signed [33:0] psum_t;
    // rounded matrix entry or rounded quaternion component before saturation
    typedef logic signed [20:0] rot_t;

    // round half up, dropping QFRAC bits
    function automatic rot_t round_q(input psum_t v);
        psum_t tmp;
        begin
            tmp = v + (psum_t'(1) <<< (QFRAC - 1));
            round_q = rot_t'(tmp >>> QFRAC);
        end
    endfunction

    // saturate to a signed 16-bit component
    function automatic qcomp_t sat_q(input rot_t v);
        begin
            if (v > rot_t'(32767))
                sat_q = 16'sh7fff;
            else if (v < -rot_t'(32768))
                sat_q = 16'sh8000;
            else
                sat_q = qcomp_t'(v);
        end
    endfunction

endpackage

`default_nettype wire

### sv/rpci_if.sv
// ============================================================================
// rpci_if
// Valid/ready channels of the pose pipeline: the request word carries a
// command and two poses, the response word carries one pose.
// ============================================================================
`default_nettype none

interface rpci_in_if import rpci_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   command;
    trans_t a_x;
    trans_t a_y;
    trans_t a_z;
    quat_t  a_quat;
    trans_t b_x;
    trans_t b_y;
    trans_t b_z;
    quat_t  b_quat;

    modport source (
        output valid, command, a_x, a_y, a_z, a_quat, b_x, b_y, b_z, b_quat,
        input  ready
    );
    modport sink (
        input  valid, command, a_x, a_y, a_z, a_quat, b_x, b_y, b_z, b_quat,
        output ready
    );
endinterface

interface rpci_out_if import rpci_pkg::*; ();
    logic   valid;
    logic   ready;
    trans_t r_x;
    trans_t r_y;
    trans_t r_z;
    quat_t  r_quat;

    modport source (
        output valid, r_x, r_y, r_z, r_quat,
        input  ready
    );
    modport sink (
        input  valid, r_x, r_y, r_z, r_quat,
        output ready
    );
endinterface

`default_nettype wire

### sv/rigid_pose_compose_invert.sv
// ============================================================================
// rigid_pose_compose_invert
// Five-stage pipeline that composes two rigid poses or inverts one.
// ============================================================================
// Usage:
//   req carries one word per item: command (0 compose, 1 invert), pose a and
//   pose b (Q16.16 translation, packed Q2.14 quaternion w,x,y,z). rsp carries
//   the resulting pose, saturated to the field ranges.
//   A word is taken at each clock edge with valid and ready high on req; one
//   word leaves on rsp per word taken, in order.
//   A taken word passes through five register stages before it shows on rsp.
//   Throughput is one word per cycle unless rsp stalls; the multiplier
//   stages (quaternion products, then matrix times translation) are each a
//   single registered stage. Each stage holds a valid bit and advances when
//   the next stage is empty or advancing, so bubbles are squeezed out and req
//   stays ready while the output register waits as long as some stage is
//   empty. When rsp stalls with every stage full, req.ready drops in the
//   same cycle; nothing is lost or repeated.
//   Reset (rst_n low, asynchronous) empties every stage; data registers keep
//   whatever they held.
// ============================================================================
`default_nettype none

module rigid_pose_compose_invert
    import rpci_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    rpci_in_if.sink     req,
    rpci_out_if.source  rsp
);

    typedef logic signed [31:0] sq_t;     // 16x16 product
    typedef logic signed [52:0] rprod_t;  // entry times translation
    typedef logic signed [55:0] tsum_t;   // sum of three, negated
    typedef logic signed [41:0] rtr_t;    // rounded rotated translation
    typedef logic signed [42:0] tfin_t;   // after adding translation

    localparam psum_t ONE_2Q   = psum_t'(1) <<< (2 * QFRAC);
    localparam tsum_t HALF_T   = tsum_t'(1) <<< (QFRAC - 1);
    localparam tfin_t TRANS_MAX = tfin_t'(64'sd2147483647);
    localparam tfin_t TRANS_MIN = tfin_t'(-64'sd2147483648);

    // stage handshake
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // stage 1: operands and 16x16 products
    logic   s1_cmd_reg;
    trans_t s1_ta_reg [3];
    trans_t s1_tb_reg [3];
    qcomp_t s1_qa_reg [4];
    sq_t    s1_pq_reg [4][4];
    sq_t    s1_xx_reg, s1_yy_reg, s1_zz_reg;
    sq_t    s1_xy_reg, s1_xz_reg, s1_yz_reg;
    sq_t    s1_wx_reg, s1_wy_reg, s1_wz_reg;

    // stage 2: matrix (transposed for invert), vector, result quaternion
    logic   s2_cmd_reg;
    trans_t s2_ta_reg [3];
    trans_t s2_vec_reg [3];
    rot_t   s2_m_reg [3][3];
    qcomp_t s2_qr_reg [4];

    // stage 3: matrix-vector products
    logic   s3_cmd_reg;
    trans_t s3_ta_reg [3];
    rprod_t s3_p_reg [3][3];
    qcomp_t s3_qr_reg [4];

    // stage 4: rounded rotated translation
    logic   s4_cmd_reg;
    trans_t s4_ta_reg [3];
    rtr_t   s4_rt_reg [3];
    qcomp_t s4_qr_reg [4];

    // stage 5: output word
    trans_t s5_t_reg [3];
    qcomp_t s5_q_reg [4];

    // combinational next values
    qcomp_t qa_c [4];
    qcomp_t qb_c [4];
    psum_t  m_raw [3][3];
    rot_t   m_c [3][3];
    psum_t  h_raw [4];
    qcomp_t qr_c [4];
    rtr_t   rt_c [3];
    tsum_t  s_c [3];
    tfin_t  tf_c [3];
    trans_t tsat_c [3];

    // ready chain, back to front
    assign rdy5 = !v5_reg || rsp.ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign req.ready = rdy1;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= req.valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // unpack quaternions
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            qa_c[i] = qcomp_t'(req.a_quat[63 - 16 * i -: 16]);
            qb_c[i] = qcomp_t'(req.b_quat[63 - 16 * i -: 16]);
        end
    end

    // stage 1 registers
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_cmd_reg   <= req.command;
            s1_ta_reg[0] <= req.a_x;
            s1_ta_reg[1] <= req.a_y;
            s1_ta_reg[2] <= req.a_z;
            s1_tb_reg[0] <= req.b_x;
            s1_tb_reg[1] <= req.b_y;
            s1_tb_reg[2] <= req.b_z;
            for (int i = 0; i < 4; i++)
            begin
                s1_qa_reg[i] <= qa_c[i];
                for (int j = 0; j < 4; j++)
                    s1_pq_reg[i][j] <= sq_t'(qa_c[i]) * sq_t'(qb_c[j]);
            end
            s1_xx_reg <= sq_t'(qa_c[1]) * sq_t'(qa_c[1]);
            s1_yy_reg <= sq_t'(qa_c[2]) * sq_t'(qa_c[2]);
            s1_zz_reg <= sq_t'(qa_c[3]) * sq_t'(qa_c[3]);
            s1_xy_reg <= sq_t'(qa_c[1]) * sq_t'(qa_c[2]);
            s1_xz_reg <= sq_t'(qa_c[1]) * sq_t'(qa_c[3]);
            s1_yz_reg <= sq_t'(qa_c[2]) * sq_t'(qa_c[3]);
            s1_wx_reg <= sq_t'(qa_c[0]) * sq_t'(qa_c[1]);
            s1_wy_reg <= sq_t'(qa_c[0]) * sq_t'(qa_c[2]);
            s1_wz_reg <= sq_t'(qa_c[0]) * sq_t'(qa_c[3]);
        end
    end

    // rotation matrix entries, exact then rounded
    always_comb
    begin
        m_raw[0][0] = ONE_2Q - ((psum_t'(s1_yy_reg) + psum_t'(s1_zz_reg)) <<< 1);
        m_raw[0][1] = (psum_t'(s1_xy_reg) - psum_t'(s1_wz_reg)) <<< 1;
        m_raw[0][2] = (psum_t'(s1_xz_reg) + psum_t'(s1_wy_reg)) <<< 1;
        m_raw[1][0] = (psum_t'(s1_xy_reg) + psum_t'(s1_wz_reg)) <<< 1;
        m_raw[1][1] = ONE_2Q - ((psum_t'(s1_xx_reg) + psum_t'(s1_zz_reg)) <<< 1);
        m_raw[1][2] = (psum_t'(s1_yz_reg) - psum_t'(s1_wx_reg)) <<< 1;
        m_raw[2][0] = (psum_t'(s1_xz_reg) - psum_t'(s1_wy_reg)) <<< 1;
        m_raw[2][1] = (psum_t'(s1_yz_reg) + psum_t'(s1_wx_reg)) <<< 1;
        m_raw[2][2] = ONE_2Q - ((psum_t'(s1_xx_reg) + psum_t'(s1_yy_reg)) <<< 1);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m_c[i][j] = round_q(m_raw[i][j]);
    end

    // hamilton product, or conjugate for invert
    always_comb
    begin
        h_raw[0] = psum_t'(s1_pq_reg[0][0]) - psum_t'(s1_pq_reg[1][1])
                 - psum_t'(s1_pq_reg[2][2]) - psum_t'(s1_pq_reg[3][3]);
        h_raw[1] = psum_t'(s1_pq_reg[0][1]) + psum_t'(s1_pq_reg[1][0])
                 + psum_t'(s1_pq_reg[2][3]) - psum_t'(s1_pq_reg[3][2]);
        h_raw[2] = psum_t'(s1_pq_reg[0][2]) - psum_t'(s1_pq_reg[1][3])
                 + psum_t'(s1_pq_reg[2][0]) + psum_t'(s1_pq_reg[3][1]);
        h_raw[3] = psum_t'(s1_pq_reg[0][3]) + psum_t'(s1_pq_reg[1][2])
                 - psum_t'(s1_pq_reg[2][1]) + psum_t'(s1_pq_reg[3][0]);
        if (s1_cmd_reg == CMD_INVERT)
        begin
            qr_c[0] = s1_qa_reg[0];
            for (int i = 1; i < 4; i++)
                qr_c[i] = sat_q(-rot_t'(s1_qa_reg[i]));
        end
        else
        begin
            for (int i = 0; i < 4; i++)
                qr_c[i] = sat_q(round_q(h_raw[i]));
        end
    end

    // stage 2 registers
    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_cmd_reg <= s1_cmd_reg;
            for (int i = 0; i < 3; i++)
            begin
                s2_ta_reg[i]  <= s1_ta_reg[i];
                s2_vec_reg[i] <= (s1_cmd_reg == CMD_INVERT) ? s1_ta_reg[i] : s1_tb_reg[i];
                for (int j = 0; j < 3; j++)
                    s2_m_reg[i][j] <= (s1_cmd_reg == CMD_INVERT) ? m_c[j][i] : m_c[i][j];
            end
            for (int i = 0; i < 4; i++)
                s2_qr_reg[i] <= qr_c[i];
        end
    end

    // stage 3 registers: matrix times vector, one product per entry
    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_cmd_reg <= s2_cmd_reg;
            for (int i = 0; i < 3; i++)
            begin
                s3_ta_reg[i] <= s2_ta_reg[i];
                for (int j = 0; j < 3; j++)
                    s3_p_reg[i][j] <= rprod_t'(s2_m_reg[i][j]) * rprod_t'(s2_vec_reg[j]);
            end
            for (int i = 0; i < 4; i++)
                s3_qr_reg[i] <= s2_qr_reg[i];
        end
    end

    // row sums, negate for invert, round
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s_c[i] = tsum_t'(s3_p_reg[i][0]) + tsum_t'(s3_p_reg[i][1])
                   + tsum_t'(s3_p_reg[i][2]);
            if (s3_cmd_reg == CMD_INVERT)
                s_c[i] = -s_c[i];
            rt_c[i] = rtr_t'((s_c[i] + HALF_T) >>> QFRAC);
        end
    end

    // stage 4 registers
    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            s4_cmd_reg <= s3_cmd_reg;
            for (int i = 0; i < 3; i++)
            begin
                s4_ta_reg[i] <= s3_ta_reg[i];
                s4_rt_reg[i] <= rt_c[i];
            end
            for (int i = 0; i < 4; i++)
                s4_qr_reg[i] <= s3_qr_reg[i];
        end
    end

    // add translation for compose, saturate
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (s4_cmd_reg == CMD_INVERT)
                tf_c[i] = tfin_t'(s4_rt_reg[i]);
            else
                tf_c[i] = tfin_t'(s4_rt_reg[i]) + tfin_t'(s4_ta_reg[i]);
            if (tf_c[i] > TRANS_MAX)
                tsat_c[i] = 32'sh7fffffff;
            else if (tf_c[i] < TRANS_MIN)
                tsat_c[i] = 32'sh80000000;
            else
                tsat_c[i] = trans_t'(tf_c[i]);
        end
    end

    // stage 5: output register
    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            for (int i = 0; i < 3; i++)
                s5_t_reg[i] <= tsat_c[i];
            for (int i = 0; i < 4; i++)
                s5_q_reg[i] <= s4_qr_reg[i];
        end
    end

    assign rsp.valid  = v5_reg;
    assign rsp.r_x    = s5_t_reg[0];
    assign rsp.r_y    = s5_t_reg[1];
    assign rsp.r_z    = s5_t_reg[2];
    assign rsp.r_quat = {s5_q_reg[0], s5_q_reg[1], s5_q_reg[2], s5_q_reg[3]};

`ifndef SYNTHESIS
    // invert keeps the scalar part of the quaternion
    a_invert_keeps_w: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && rdy2 && (s1_cmd_reg == CMD_INVERT)
        |=> s2_qr_reg[0] == $past(s1_qa_reg[0]))
        else $error("invert changed quaternion w");

    // a full stage 4 holds its word while the output register is blocked
    a_stage4_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && !rdy5
        |=> v4_reg && $stable(s4_rt_reg[0]) && $stable(s4_rt_reg[1])
            && $stable(s4_rt_reg[2]) && $stable(s4_cmd_reg))
        else $error("stage 4 word lost under stall");

    // a blocked output never takes new data
    a_output_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready
        |=> rsp.valid && $stable(rsp.r_x) && $stable(rsp.r_quat))
        else $error("output word overwritten under stall");
`endif

endmodule

`default_nettype wire

### tb/tb_rigid_pose_compose_invert.sv
// ============================================================================
// tb_rigid_pose_compose_invert
// Self-checking bench for the pose compose / invert pipeline. A directed
// table covers identity, zero and extreme quaternions and translation
// saturation. Random pose pairs follow. Every response word is checked
// field by field against a literal result or an in-bench fixed-point predictor. Both channels
// idle and stall at random.
// ============================================================================
`default_nettype none

module tb_rigid_pose_compose_invert;

    import rpci_pkg::*;

    localparam int     CYCLE_LIMIT  = 200000;
    localparam int     DIR_ROWS     = 21;
    localparam int     RAND_BLOCKS  = 8;
    localparam int     BLOCK_WORDS  = 100;
    localparam int     TAIL_CYCLES  = 8;

    localparam quat_t  Q_ID   = 64'h4000_0000_0000_0000;
    localparam quat_t  Q_ZERO = 64'h0;
    localparam quat_t  Q_90Z  = 64'h2d41_0000_0000_2d41;
    localparam quat_t  Q_180X = 64'h0000_4000_0000_0000;
    localparam trans_t T_MAX  = 32'h7fff_ffff;
    localparam trans_t T_MIN  = 32'h8000_0000;
    localparam trans_t T_ONES = 32'hffff_ffff;

    typedef struct packed {
        logic   command;
        trans_t a_x;
        trans_t a_y;
        trans_t a_z;
        quat_t  a_quat;
        trans_t b_x;
        trans_t b_y;
        trans_t b_z;
        quat_t  b_quat;
    } pose_req_t;

    typedef struct packed {
        trans_t r_x;
        trans_t r_y;
        trans_t r_z;
        quat_t  r_quat;
    } pose_res_t;

    typedef struct packed {
        logic      has_lit;
        pose_req_t stim;
        pose_res_t lit;
    } pose_row_t;

    localparam pose_res_t NO_LIT = '0;

    logic clk;
    logic rst_n;

    rpci_in_if  req ();
    rpci_out_if rsp ();

    rigid_pose_compose_invert u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    pose_res_t awaited_poses [$];
    pose_res_t staged_pose;
    int        bad_fields = 0;
    int        cycle_count = 0;
    logic      src_idle_on;
    logic      snk_idle_on;

    // directed words: literal results only where they are obvious
    pose_row_t dir_table [DIR_ROWS] = '{
        // identity compose adds translations
        '{1'b1, '{CMD_COMPOSE, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, Q_ID,
                  32'h0004_0000, 32'h0005_0000, 32'h0006_0000, Q_ID},
                '{32'h0005_0000, 32'h0007_0000, 32'h0009_0000, Q_ID}},
        // identity invert negates translation
        '{1'b1, '{CMD_INVERT, 32'h0001_0000, 32'hfffe_0000, 32'h0003_0000, Q_ID,
                  32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f, 64'hffff_0000_ffff_0000},
                '{32'hffff_0000, 32'h0002_0000, 32'hfffd_0000, Q_ID}},
        // negated most negative translation saturates
        '{1'b1, '{CMD_INVERT, T_MIN, T_MAX, 32'h0, Q_ID,
                  T_ONES, T_ONES, T_ONES, 64'hffff_ffff_ffff_ffff},
                '{T_MAX, 32'h8000_0001, 32'h0, Q_ID}},
        // translation sum saturates both ways
        '{1'b1, '{CMD_COMPOSE, T_MAX, T_MIN, T_MIN, Q_ID, T_MAX, T_MIN, T_MAX, Q_ID},
                '{T_MAX, T_MIN, T_ONES, Q_ID}},
        // conjugate of the most negative component saturates
        '{1'b1, '{CMD_INVERT, 32'h0, 32'h0, 32'h0, 64'h4000_8000_8000_8000,
                  32'h0, 32'h0, 32'h0, Q_ZERO},
                '{32'h0, 32'h0, 32'h0, 64'h4000_7fff_7fff_7fff}},
        // zero quaternion still gives an identity matrix, product is zero
        '{1'b1, '{CMD_COMPOSE, 32'h0001_8000, 32'hfff0_0000, 32'h0000_0007, Q_ZERO,
                  32'h0000_4000, 32'h0000_0001, 32'hffff_fff9, 64'h7fff_8000_1234_abcd},
                '{32'h0001_c000, 32'hfff0_0001, 32'h0, Q_ZERO}},
        // all zero compose
        '{1'b1, '{CMD_COMPOSE, 32'h0, 32'h0, 32'h0, Q_ZERO, 32'h0, 32'h0, 32'h0, Q_ZERO},
                '{32'h0, 32'h0, 32'h0, Q_ZERO}},
        // all zero invert, pose b ignored
        '{1'b1, '{CMD_INVERT, 32'h0, 32'h0, 32'h0, Q_ZERO,
                  T_ONES, T_ONES, T_ONES, 64'hffff_ffff_ffff_ffff},
                '{32'h0, 32'h0, 32'h0, Q_ZERO}},
        // identity a at origin passes pose b through
        '{1'b1, '{CMD_COMPOSE, 32'h0, 32'h0, 32'h0, Q_ID,
                  T_MAX, T_MIN, 32'h1234_5678, 64'h8000_7fff_0001_ffff},
                '{T_MAX, T_MIN, 32'h1234_5678, 64'h8000_7fff_0001_ffff}},
        // extreme quaternions and translations
        '{1'b0, '{CMD_COMPOSE, T_MAX, T_MAX, T_MAX, 64'h8000_8000_8000_8000,
                  T_MAX, T_MAX, T_MAX, 64'h8000_8000_8000_8000}, NO_LIT},
        '{1'b0, '{CMD_COMPOSE, T_MIN, T_MIN, T_MIN, 64'h7fff_7fff_7fff_7fff,
                  T_MIN, T_MIN, T_MIN, 64'h7fff_7fff_7fff_7fff}, NO_LIT},
        '{1'b0, '{CMD_INVERT, T_MAX, T_MAX, T_MAX, 64'h8000_8000_8000_8000,
                  32'h0, 32'h0, 32'h0, Q_ZERO}, NO_LIT},
        '{1'b0, '{CMD_INVERT, T_MIN, T_MIN, T_MIN, 64'h7fff_7fff_7fff_7fff,
                  T_MAX, T_MAX, T_MAX, 64'h7fff_7fff_7fff_7fff}, NO_LIT},
        // quarter turn about z
        '{1'b0, '{CMD_COMPOSE, 32'h0001_0000, 32'h0, 32'h0, Q_90Z,
                  32'h0002_0000, 32'h0, 32'h0, Q_90Z}, NO_LIT},
        '{1'b0, '{CMD_INVERT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, Q_90Z,
                  32'h0, 32'h0, 32'h0, Q_ZERO}, NO_LIT},
        // all ones
        '{1'b0, '{CMD_COMPOSE, T_ONES, T_ONES, T_ONES, 64'hffff_ffff_ffff_ffff,
                  T_ONES, T_ONES, T_ONES, 64'hffff_ffff_ffff_ffff}, NO_LIT},
        '{1'b0, '{CMD_INVERT, T_ONES, T_ONES, T_ONES, 64'hffff_ffff_ffff_ffff,
                  T_ONES, T_ONES, T_ONES, 64'hffff_ffff_ffff_ffff}, NO_LIT},
        // non-unit quaternions, product saturates
        '{1'b0, '{CMD_COMPOSE, 32'h1000_0000, 32'h1000_0000, 32'h1000_0000,
                  64'h7fff_0000_0000_0000, 32'h1000_0000, 32'h1000_0000, 32'h1000_0000,
                  64'h7fff_0000_0000_0000}, NO_LIT},
        // general rotations
        '{1'b0, '{CMD_COMPOSE, 32'h0123_4567, 32'hfedc_ba98, 32'h0040_0000,
                  64'h3b21_187e_0c3f_e4a9, 32'hff80_0000, 32'h0055_5555, 32'hffff_8000,
                  64'hd2bf_1f03_e0fd_2d41}, NO_LIT},
        // half turn about x
        '{1'b0, '{CMD_INVERT, T_MAX, T_MIN, 32'h1234_5678, Q_180X,
                  32'h0, 32'h0, 32'h0, Q_ZERO}, NO_LIT},
        '{1'b0, '{CMD_COMPOSE, 32'h0, 32'h0, 32'h0, Q_180X,
                  T_MIN, T_MIN, T_MIN, Q_180X}, NO_LIT}
    };

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // fixed-point helpers
    function automatic longint round_half(input longint v);
        return (v + (longint'(1) <<< (QFRAC - 1))) >>> QFRAC;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // pose composition or inversion at the block's fixed-point precision
    function automatic pose_res_t compose_or_invert_pose(input pose_req_t w);
        longint    qa [4];
        longint    qb [4];
        longint    qr [4];
        longint    ta [3];
        longint    tb [3];
        longint    tr [3];
        longint    rm [3][3];
        longint    unity;
        longint    acc;
        pose_res_t res;
        int        i;
        int        j;
        unity = longint'(1) <<< (2 * QFRAC);
        for (i = 0; i < 4; i++)
        begin
            qa[i] = $signed(w.a_quat[63 - 16 * i -: 16]);
            qb[i] = $signed(w.b_quat[63 - 16 * i -: 16]);
        end
        ta[0] = $signed(w.a_x);
        ta[1] = $signed(w.a_y);
        ta[2] = $signed(w.a_z);
        tb[0] = $signed(w.b_x);
        tb[1] = $signed(w.b_y);
        tb[2] = $signed(w.b_z);

        // rotation matrix of pose a, entries rounded to QFRAC bits
        rm[0][0] = round_half(unity - 2 * (qa[2] * qa[2] + qa[3] * qa[3]));
        rm[0][1] = round_half(2 * (qa[1] * qa[2] - qa[0] * qa[3]));
        rm[0][2] = round_half(2 * (qa[1] * qa[3] + qa[0] * qa[2]));
        rm[1][0] = round_half(2 * (qa[1] * qa[2] + qa[0] * qa[3]));
        rm[1][1] = round_half(unity - 2 * (qa[1] * qa[1] + qa[3] * qa[3]));
        rm[1][2] = round_half(2 * (qa[2] * qa[3] - qa[0] * qa[1]));
        rm[2][0] = round_half(2 * (qa[1] * qa[3] - qa[0] * qa[2]));
        rm[2][1] = round_half(2 * (qa[2] * qa[3] + qa[0] * qa[1]));
        rm[2][2] = round_half(unity - 2 * (qa[1] * qa[1] + qa[2] * qa[2]));

        if (w.command == CMD_COMPOSE)
        begin
            for (i = 0; i < 3; i++)
            begin
                acc = 0;
                for (j = 0; j < 3; j++)
                    acc += rm[i][j] * tb[j];
                tr[i] = ta[i] + round_half(acc);
            end
            // hamilton product
            qr[0] = round_half(qa[0] * qb[0] - qa[1] * qb[1] - qa[2] * qb[2] - qa[3] * qb[3]);
            qr[1] = round_half(qa[0] * qb[1] + qa[1] * qb[0] + qa[2] * qb[3] - qa[3] * qb[2]);
            qr[2] = round_half(qa[0] * qb[2] - qa[1] * qb[3] + qa[2] * qb[0] + qa[3] * qb[1]);
            qr[3] = round_half(qa[0] * qb[3] + qa[1] * qb[2] - qa[2] * qb[1] + qa[3] * qb[0]);
        end
        else
        begin
            // transposed matrix, negated before rounding
            for (i = 0; i < 3; i++)
            begin
                acc = 0;
                for (j = 0; j < 3; j++)
                    acc += rm[j][i] * ta[j];
                tr[i] = round_half(-acc);
            end
            qr[0] = qa[0];
            qr[1] = -qa[1];
            qr[2] = -qa[2];
            qr[3] = -qa[3];
        end

        res.r_x = trans_t'(clamp(tr[0], -64'sd2147483648, 64'sd2147483647));
        res.r_y = trans_t'(clamp(tr[1], -64'sd2147483648, 64'sd2147483647));
        res.r_z = trans_t'(clamp(tr[2], -64'sd2147483648, 64'sd2147483647));
        for (i = 0; i < 4; i++)
            res.r_quat[63 - 16 * i -: 16] = 16'(clamp(qr[i], -32768, 32767));
        return res;
    endfunction

    // random translation: mostly moderate, sometimes full range or extreme
    function automatic trans_t rand_trans();
        case ($urandom_range(0, 9)) inside
            0:
                case ($urandom_range(0, 2))
                    0:       return T_MAX;
                    1:       return T_MIN;
                    default: return 32'h0;
                endcase
            [1:6]:
                return trans_t'(int'($urandom_range(0, 32'h07ff_ffff)) - 32'sh0400_0000);
            default:
                return trans_t'($urandom);
        endcase
    endfunction

    // random quaternion: mostly close to unit length
    function automatic quat_t rand_quat();
        real   c [4];
        real   norm;
        quat_t q;
        int    k;
        case ($urandom_range(0, 9)) inside
            [0:5]:
            begin
                norm = 0.0;
                for (k = 0; k < 4; k++)
                begin
                    c[k] = ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
                    norm += c[k] * c[k];
                end
                norm = $sqrt(norm);
                if (norm < 0.01)
                    return Q_ID;
                for (k = 0; k < 4; k++)
                    q[63 - 16 * k -: 16] = 16'($rtoi(c[k] / norm * 16384.0));
                return q;
            end
            6:
            begin
                for (k = 0; k < 4; k++)
                    case ($urandom_range(0, 5))
                        0:       q[63 - 16 * k -: 16] = 16'h8000;
                        1:       q[63 - 16 * k -: 16] = 16'h7fff;
                        2:       q[63 - 16 * k -: 16] = 16'h0000;
                        3:       q[63 - 16 * k -: 16] = 16'h4000;
                        4:       q[63 - 16 * k -: 16] = 16'hc000;
                        default: q[63 - 16 * k -: 16] = 16'hffff;
                    endcase
                return q;
            end
            default:
                return {$urandom, $urandom};
        endcase
    endfunction

    function automatic pose_req_t rand_request();
        pose_req_t w;
        w.command = ($urandom_range(0, 1) == 0) ? CMD_COMPOSE : CMD_INVERT;
        w.a_x     = rand_trans();
        w.a_y     = rand_trans();
        w.a_z     = rand_trans();
        w.a_quat  = rand_quat();
        w.b_x     = rand_trans();
        w.b_y     = rand_trans();
        w.b_z     = rand_trans();
        w.b_quat  = rand_quat();
        return w;
    endfunction

    // drive one request word, called and returning at a falling edge
    task automatic send_word(input pose_req_t w, input pose_res_t want);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid   <= 1'b1;
        req.command <= w.command;
        req.a_x     <= w.a_x;
        req.a_y     <= w.a_y;
        req.a_z     <= w.a_z;
        req.a_quat  <= w.a_quat;
        req.b_x     <= w.b_x;
        req.b_y     <= w.b_y;
        req.b_z     <= w.b_z;
        req.b_quat  <= w.b_quat;
        staged_pose <= want;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // hold the sender until every response has come back
    task automatic drain_pipeline();
        req.valid <= 1'b0;
        @(negedge clk);
        while (awaited_poses.size() != 0)
            @(negedge clk);
    endtask

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, actual %h", name, want, got);
            bad_fields++;
        end
    endfunction

    // scoreboard: record accepted requests, check responses in order
    always @(posedge clk)
    begin
        pose_res_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
                awaited_poses.push_back(staged_pose);
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_poses.size() == 0)
                begin
                    $error("response word with no request pending");
                    bad_fields++;
                end
                else
                begin
                    want = awaited_poses.pop_front();
                    compare_field("r_x", 64'(want.r_x), 64'(rsp.r_x));
                    compare_field("r_y", 64'(want.r_y), 64'(rsp.r_y));
                    compare_field("r_z", 64'(want.r_z), 64'(rsp.r_z));
                    compare_field("r_quat", want.r_quat, rsp.r_quat);
                end
            end
        end
    end

    // run time guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_rigid_pose_compose_invert failed");
            $finish;
        end
    end

    // response side: random stall before each word
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            stall = snk_idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // request side and run control
    initial
    begin
        pose_req_t w;
        int        r;
        int        blk;
        int        k;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        staged_pose = '0;
        rst_n       = 1'b0;
        req.valid   = 1'b0;
        req.command = CMD_COMPOSE;
        req.a_x     = '0;
        req.a_y     = '0;
        req.a_z     = '0;
        req.a_quat  = '0;
        req.b_x     = '0;
        req.b_y     = '0;
        req.b_z     = '0;
        req.b_quat  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (r = 0; r < DIR_ROWS; r++)
            send_word(dir_table[r].stim,
                      dir_table[r].has_lit ? dir_table[r].lit
                                           : compose_or_invert_pose(dir_table[r].stim));
        drain_pipeline();

        // random pose pairs, idling pattern changes per block
        for (blk = 0; blk < RAND_BLOCKS; blk++)
        begin
            src_idle_on = blk[0];
            snk_idle_on = blk[1];
            if (blk == RAND_BLOCKS / 2)
                drain_pipeline();
            for (k = 0; k < BLOCK_WORDS; k++)
            begin
                w = rand_request();
                send_word(w, compose_or_invert_pose(w));
            end
        end

        drain_pipeline();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (bad_fields == 0)
            $display("tb_rigid_pose_compose_invert passed");
        else
            $display("tb_rigid_pose_compose_invert failed");
        $finish;
    end

endmodule

`default_nettype wire

### rigid_pose_compose_invert.f
sv/rpci_pkg.sv
sv/rpci_if.sv
sv/rigid_pose_compose_invert.sv
tb/tb_rigid_pose_compose_invert.sv
